[src/dsmr_pkg.sv]
// ----------------------------------------------------------------------------
// dsmr_pkg
// Shared types and constants of the round-by-round stable matching core.
// ----------------------------------------------------------------------------
package dsmr_pkg;

   localparam int CFG_W = 5;   // config registers, man index, choice pointer
   localparam int FLD_W = 4;   // input item fields, table entries
   localparam int CNT_W = 6;   // pass counter, counts to num_men + 2
   localparam int DAY_W = 9;
   localparam int REJ_W = 5;

   localparam logic [CFG_W-1:0] NO_SUITOR = 5'd16;
   localparam logic [CFG_W-1:0] CFG_RESET = 5'd16;
   localparam logic [DAY_W-1:0] DAY_MAX   = 9'd511;
   localparam logic [REJ_W-1:0] REJ_MAX   = 5'd31;

   localparam int CSR_IDX_W = 1;
   localparam logic [CSR_IDX_W-1:0] CSR_NUM_MEN   = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_NUM_WOMEN = 1'b1;

   typedef enum logic [1:0] {
      KIND_LOAD_CHOICE = 2'd0,
      KIND_LOAD_RANK   = 2'd1,
      KIND_START       = 2'd2,
      KIND_RUN_DAY     = 2'd3
   } kind_type;

   typedef enum logic [1:0] {
      ST_IDLE   = 2'd0,
      ST_OFFER  = 2'd1,
      ST_REJECT = 2'd2
   } state_type;

   // table load, one entry per transfer
   typedef struct packed {
      logic             choice_we;
      logic             rank_we;
      logic [FLD_W-1:0] row;
      logic [FLD_W-1:0] col;
      logic [FLD_W-1:0] data;
   } load_type;

   // table read addresses
   typedef struct packed {
      logic [CFG_W-1:0] ch_man;
      logic [CFG_W-1:0] ch_pos;
      logic [FLD_W-1:0] rk_woman;
      logic [CFG_W-1:0] rk_man;
   } tbl_rd_type;

   // per-person state access
   typedef struct packed {
      logic             clear;
      logic [CFG_W-1:0] nc_rd_man;
      logic             nc_we;
      logic [CFG_W-1:0] nc_wr_man;
      logic [CFG_W-1:0] nc_wr_data;
      logic [FLD_W-1:0] br_rd_woman;
      logic             br_we;
      logic [FLD_W-1:0] br_wr_woman;
      logic [CFG_W-1:0] br_wr_data;
   } ppl_req_type;

endpackage

[src/dsmr_tables.sv]
// ----------------------------------------------------------------------------
// dsmr_tables
// Preference memories: choice list per proposer and rank per acceptor.
// ----------------------------------------------------------------------------
module dsmr_tables #(
   parameter int MAX_MEN   = 16,
   parameter int MAX_WOMEN = 16
) (
   input  logic                      clock,
   input  dsmr_pkg::load_type        load,
   input  dsmr_pkg::tbl_rd_type      rd,
   output logic [dsmr_pkg::FLD_W-1:0] ch_rd_data,
   output logic [dsmr_pkg::FLD_W-1:0] rk_rd_data
);
   import dsmr_pkg::*;

   localparam int DEPTH = MAX_MEN * MAX_WOMEN;
   localparam int AW    = $clog2(DEPTH);

   logic [FLD_W-1:0] choice_mem [DEPTH];
   logic [FLD_W-1:0] rank_mem   [DEPTH];
   logic [FLD_W-1:0] ch_rd_ff;
   logic [FLD_W-1:0] rk_rd_ff;
   logic [AW-1:0]    ch_wr_ad, rk_wr_ad, ch_rd_ad, rk_rd_ad;
   logic             ch_in_range, rk_in_range;

   always_comb begin
      ch_in_range = (32'(load.row) < MAX_MEN) && (32'(load.col) < MAX_WOMEN);
      rk_in_range = (32'(load.row) < MAX_WOMEN) && (32'(load.col) < MAX_MEN);
      ch_wr_ad = AW'(32'(load.row) * MAX_WOMEN + 32'(load.col));
      rk_wr_ad = AW'(32'(load.row) * MAX_MEN + 32'(load.col));
      ch_rd_ad = AW'(32'(rd.ch_man) * MAX_WOMEN + 32'(rd.ch_pos));
      rk_rd_ad = AW'(32'(rd.rk_woman) * MAX_MEN + 32'(rd.rk_man));
   end

   always_ff @(posedge clock) begin
      if (load.choice_we && ch_in_range) begin
         choice_mem[ch_wr_ad] <= load.data;
      end
      ch_rd_ff <= choice_mem[ch_rd_ad];
   end

   always_ff @(posedge clock) begin
      if (load.rank_we && rk_in_range) begin
         rank_mem[rk_wr_ad] <= load.data;
      end
      rk_rd_ff <= rank_mem[rk_rd_ad];
   end

   assign ch_rd_data = ch_rd_ff;
   assign rk_rd_data = rk_rd_ff;

endmodule

[src/dsmr_people.sv]
// ----------------------------------------------------------------------------
// dsmr_people
// Per-person state: next choice of each proposer, best rank of each acceptor.
// Valid bits give the rewind values without a clearing pass.
// ----------------------------------------------------------------------------
module dsmr_people #(
   parameter int MAX_MEN   = 16,
   parameter int MAX_WOMEN = 16
) (
   input  logic                      clock,
   input  logic                      reset,
   input  dsmr_pkg::ppl_req_type     req,
   output logic [dsmr_pkg::CFG_W-1:0] nc_rd_data,
   output logic [dsmr_pkg::CFG_W-1:0] br_rd_data
);
   import dsmr_pkg::*;

   localparam int MM_W = $clog2(MAX_MEN);
   localparam int MW_W = $clog2(MAX_WOMEN);

   logic [CFG_W-1:0]     nc_mem [MAX_MEN];
   logic [CFG_W-1:0]     br_mem [MAX_WOMEN];
   logic [MAX_MEN-1:0]   nc_vld_ff;
   logic [MAX_WOMEN-1:0] br_vld_ff;
   logic [CFG_W-1:0]     nc_rd_ff, br_rd_ff;
   logic                 nc_hit_ff, br_hit_ff;
   logic [MM_W-1:0]      nc_rd_ix, nc_wr_ix;
   logic [MW_W-1:0]      br_rd_ix, br_wr_ix;

   assign nc_rd_ix = MM_W'(req.nc_rd_man);
   assign nc_wr_ix = MM_W'(req.nc_wr_man);
   assign br_rd_ix = MW_W'(req.br_rd_woman);
   assign br_wr_ix = MW_W'(req.br_wr_woman);

   always_ff @(posedge clock) begin
      if (reset || req.clear) begin
         nc_vld_ff <= '0;
         br_vld_ff <= '0;
      end else begin
         if (req.nc_we) begin
            nc_vld_ff[nc_wr_ix] <= 1'b1;
         end
         if (req.br_we) begin
            br_vld_ff[br_wr_ix] <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req.nc_we) begin
         nc_mem[nc_wr_ix] <= req.nc_wr_data;
      end
      nc_rd_ff  <= nc_mem[nc_rd_ix];
      nc_hit_ff <= nc_vld_ff[nc_rd_ix];
   end

   always_ff @(posedge clock) begin
      if (req.br_we) begin
         br_mem[br_wr_ix] <= req.br_wr_data;
      end
      br_rd_ff  <= br_mem[br_rd_ix];
      br_hit_ff <= br_vld_ff[br_rd_ix];
   end

   assign nc_rd_data = nc_hit_ff ? nc_rd_ff : '0;
   assign br_rd_data = br_hit_ff ? br_rd_ff : NO_SUITOR;

endmodule

[src/dsmr_seq.sv]
// ----------------------------------------------------------------------------
// dsmr_seq
// Day sequencer: offer pass then rejection pass over all proposers in use
// through one four-stage lookup pipeline and the rank compares of stage D.
// ----------------------------------------------------------------------------
module dsmr_seq #(
   parameter int MAX_MEN   = 16,
   parameter int MAX_WOMEN = 16
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   output logic                       busy,
   input  logic [1:0]                 req_kind,
   input  logic [dsmr_pkg::FLD_W-1:0] req_person,
   input  logic [dsmr_pkg::FLD_W-1:0] req_position,
   input  logic [dsmr_pkg::FLD_W-1:0] req_value,
   input  logic [dsmr_pkg::CFG_W-1:0] num_men,
   input  logic [dsmr_pkg::CFG_W-1:0] num_women,
   output dsmr_pkg::load_type         load,
   output dsmr_pkg::tbl_rd_type       tbl_rd,
   input  logic [dsmr_pkg::FLD_W-1:0] ch_rd_data,
   input  logic [dsmr_pkg::FLD_W-1:0] rk_rd_data,
   output dsmr_pkg::ppl_req_type      ppl,
   input  logic [dsmr_pkg::CFG_W-1:0] nc_rd_data,
   input  logic [dsmr_pkg::CFG_W-1:0] br_rd_data,
   output logic                       rsp_strobe,
   output logic [dsmr_pkg::DAY_W-1:0] rsp_day_number,
   output logic [dsmr_pkg::REJ_W-1:0] rsp_rejections,
   output logic                       rsp_finished
);
   import dsmr_pkg::*;

   state_type        state_ff, state_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [REJ_W-1:0] rej_ff, rej_in, rej_next;
   logic [DAY_W-1:0] day_ff, day_in;

   // pipeline: B has next choice, C has acceptor, D has rank and best rank
   logic             vb_ff, vc_ff, vd_ff, wokd_ff;
   logic [CFG_W-1:0] mb_ff, mc_ff, md_ff, pc_ff, pd_ff;
   logic [FLD_W-1:0] wd_ff;
   logic             issue, act_b, wok_c;

   // bypass of the best-rank write made in the previous cycle
   logic             fwd_vld_ff;
   logic [FLD_W-1:0] fwd_w_ff;
   logic [CFG_W-1:0] fwd_val_ff;

   logic [CFG_W-1:0] nm, nw, rank_d, best_eff;
   logic             last, offer_hit, reject;

   logic             rsp_strobe_ff, rsp_strobe_in;
   logic [DAY_W-1:0] rsp_day_ff, rsp_day_in;
   logic [REJ_W-1:0] rsp_rej_ff, rsp_rej_in;
   logic             rsp_fin_ff, rsp_fin_in;

   assign nm = (32'(num_men) > MAX_MEN) ? CFG_W'(MAX_MEN) : num_men;
   assign nw = (32'(num_women) > MAX_WOMEN) ? CFG_W'(MAX_WOMEN) : num_women;

   assign busy  = (state_ff != ST_IDLE);
   assign last  = (cnt_ff == {1'b0, nm} + CNT_W'(2));
   assign issue = (state_ff != ST_IDLE) && (cnt_ff < {1'b0, nm});

   assign act_b = vb_ff && (nc_rd_data < nw);
   assign wok_c = ({1'b0, ch_rd_data} < nw);

   assign rank_d    = {1'b0, rk_rd_data};
   assign best_eff  = (fwd_vld_ff && fwd_w_ff == wd_ff) ? fwd_val_ff : br_rd_data;
   assign offer_hit = (state_ff == ST_OFFER) && vd_ff && wokd_ff && (rank_d < best_eff);
   assign reject    = (state_ff == ST_REJECT) && vd_ff && (!wokd_ff || rank_d > best_eff);
   assign rej_next  = (reject && rej_ff != REJ_MAX) ? rej_ff + REJ_W'(1) : rej_ff;

   always_comb begin
      load.choice_we = 1'b0;
      load.rank_we   = 1'b0;
      load.row       = req_person;
      load.col       = req_position;
      load.data      = req_value;

      tbl_rd.ch_man   = mb_ff;
      tbl_rd.ch_pos   = nc_rd_data;
      tbl_rd.rk_woman = ch_rd_data;
      tbl_rd.rk_man   = mc_ff;

      ppl.clear       = 1'b0;
      ppl.nc_rd_man   = cnt_ff[CFG_W-1:0];
      ppl.nc_we       = reject;
      ppl.nc_wr_man   = md_ff;
      ppl.nc_wr_data  = pd_ff + CFG_W'(1);
      ppl.br_rd_woman = ch_rd_data;
      ppl.br_we       = offer_hit;
      ppl.br_wr_woman = wd_ff;
      ppl.br_wr_data  = rank_d;

      state_in      = state_ff;
      cnt_in        = cnt_ff;
      rej_in        = rej_ff;
      day_in        = day_ff;
      rsp_strobe_in = 1'b0;
      rsp_day_in    = rsp_day_ff;
      rsp_rej_in    = rsp_rej_ff;
      rsp_fin_in    = rsp_fin_ff;

      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               case (kind_type'(req_kind))
                  KIND_LOAD_CHOICE: load.choice_we = 1'b1;
                  KIND_LOAD_RANK:   load.rank_we = 1'b1;
                  KIND_START: begin
                     ppl.clear = 1'b1;
                     day_in    = '0;
                  end
                  KIND_RUN_DAY: begin
                     state_in = ST_OFFER;
                     cnt_in   = '0;
                     rej_in   = '0;
                  end
                  default: state_in = ST_IDLE;
               endcase
            end
         end
         ST_OFFER: begin
            if (last) begin
               state_in = ST_REJECT;
               cnt_in   = '0;
            end else begin
               cnt_in = cnt_ff + CNT_W'(1);
            end
         end
         ST_REJECT: begin
            rej_in = rej_next;
            if (last) begin
               state_in      = ST_IDLE;
               rsp_strobe_in = 1'b1;
               rsp_day_in    = day_ff;
               rsp_rej_in    = rej_next;
               rsp_fin_in    = (rej_next == '0);
               if (day_ff != DAY_MAX) begin
                  day_in = day_ff + DAY_W'(1);
               end
            end else begin
               cnt_in = cnt_ff + CNT_W'(1);
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         cnt_ff        <= '0;
         rej_ff        <= '0;
         day_ff        <= '0;
         vb_ff         <= 1'b0;
         vc_ff         <= 1'b0;
         vd_ff         <= 1'b0;
         fwd_vld_ff    <= 1'b0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         cnt_ff        <= cnt_in;
         rej_ff        <= rej_in;
         day_ff        <= day_in;
         vb_ff         <= issue;
         vc_ff         <= act_b;
         vd_ff         <= vc_ff;
         fwd_vld_ff    <= offer_hit;
         rsp_strobe_ff <= rsp_strobe_in;
      end
   end

   always_ff @(posedge clock) begin
      mb_ff      <= cnt_ff[CFG_W-1:0];
      mc_ff      <= mb_ff;
      pc_ff      <= nc_rd_data;
      md_ff      <= mc_ff;
      pd_ff      <= pc_ff;
      wd_ff      <= ch_rd_data;
      wokd_ff    <= wok_c;
      fwd_w_ff   <= wd_ff;
      fwd_val_ff <= rank_d;
      rsp_day_ff <= rsp_day_in;
      rsp_rej_ff <= rsp_rej_in;
      rsp_fin_ff <= rsp_fin_in;
   end

   assign rsp_strobe     = rsp_strobe_ff;
   assign rsp_day_number = rsp_day_ff;
   assign rsp_rejections = rsp_rej_ff;
   assign rsp_finished   = rsp_fin_ff;

endmodule

[src/daily_stable_matching_rounds_core.sv]
// ----------------------------------------------------------------------------
// daily_stable_matching_rounds_core
// Round-by-round stable matching, all proposers offering in parallel.
// ----------------------------------------------------------------------------
// Usage:
//   An item transfers on a clock edge with start high and busy low.
//   req_kind selects: load a proposer's choice, load an acceptor's rank of a
//   proposer, start (rewind all proposers, clear best ranks, day count 0), or
//   run one day. Loads and start keep busy low. A day runs an offer pass and
//   a rejection pass, each streaming every proposer in use through a four-stage
//   lookup pipeline, one per cycle. rsp_strobe rises once the rejection pass
//   ends, with busy high through both passes. A new day item is not taken
//   while busy is high; the next one may transfer in the strobe cycle. The
//   result (day number, rejection count, finished) is valid for exactly one
//   cycle with rsp_strobe; the receiver cannot stall it.
//   num_men and num_women are written through csr_we/csr_index/csr_wdata;
//   the user writes them only while the core is idle, which the core does
//   not enforce; both reset to 16. Reset clears the sequencer, the rewind
//   state and the day count; the preference tables are undefined until loaded.
// ----------------------------------------------------------------------------
module daily_stable_matching_rounds_core #(
   parameter int MAX_MEN   = 16,
   parameter int MAX_WOMEN = 16
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           start,
   output logic                           busy,
   input  logic [1:0]                     req_kind,
   input  logic [dsmr_pkg::FLD_W-1:0]     req_person,
   input  logic [dsmr_pkg::FLD_W-1:0]     req_position,
   input  logic [dsmr_pkg::FLD_W-1:0]     req_value,
   output logic                           rsp_strobe,
   output logic [dsmr_pkg::DAY_W-1:0]     rsp_day_number,
   output logic [dsmr_pkg::REJ_W-1:0]     rsp_rejections,
   output logic                           rsp_finished,
   input  logic                           csr_we,
   input  logic [dsmr_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [dsmr_pkg::CFG_W-1:0]     csr_wdata
);
   import dsmr_pkg::*;

   logic [CFG_W-1:0] num_men_ff, num_women_ff;
   load_type         load;
   tbl_rd_type       tbl_rd;
   ppl_req_type      ppl;
   logic [FLD_W-1:0] ch_rd_data, rk_rd_data;
   logic [CFG_W-1:0] nc_rd_data, br_rd_data;

   always_ff @(posedge clock) begin
      if (reset) begin
         num_men_ff   <= CFG_RESET;
         num_women_ff <= CFG_RESET;
      end else if (csr_we) begin
         case (csr_index)
            CSR_NUM_MEN:   num_men_ff <= csr_wdata;
            CSR_NUM_WOMEN: num_women_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   dsmr_tables #(
      .MAX_MEN   (MAX_MEN),
      .MAX_WOMEN (MAX_WOMEN)
   ) u_tables (
      .clock      (clock),
      .load       (load),
      .rd         (tbl_rd),
      .ch_rd_data (ch_rd_data),
      .rk_rd_data (rk_rd_data)
   );

   dsmr_people #(
      .MAX_MEN   (MAX_MEN),
      .MAX_WOMEN (MAX_WOMEN)
   ) u_people (
      .clock      (clock),
      .reset      (reset),
      .req        (ppl),
      .nc_rd_data (nc_rd_data),
      .br_rd_data (br_rd_data)
   );

   dsmr_seq #(
      .MAX_MEN   (MAX_MEN),
      .MAX_WOMEN (MAX_WOMEN)
   ) u_seq (
      .clock          (clock),
      .reset          (reset),
      .start          (start),
      .busy           (busy),
      .req_kind       (req_kind),
      .req_person     (req_person),
      .req_position   (req_position),
      .req_value      (req_value),
      .num_men        (num_men_ff),
      .num_women      (num_women_ff),
      .load           (load),
      .tbl_rd         (tbl_rd),
      .ch_rd_data     (ch_rd_data),
      .rk_rd_data     (rk_rd_data),
      .ppl            (ppl),
      .nc_rd_data     (nc_rd_data),
      .br_rd_data     (br_rd_data),
      .rsp_strobe     (rsp_strobe),
      .rsp_day_number (rsp_day_number),
      .rsp_rejections (rsp_rejections),
      .rsp_finished   (rsp_finished)
   );

endmodule
